// File: rtl/idp_pkg.sv
`default_nettype none

package idp_pkg;

  // field width limit, saturates larger pad magnitudes
  localparam int MAX_FIELD_WIDTH = 32;
  localparam int CNT_W = $clog2(MAX_FIELD_WIDTH + 1);

  localparam int VALUE_W = 32;
  localparam int PAD_W = 7;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W = 4 * NUM_DIGITS;
  localparam int NDIG_W = 4;
  localparam int BIT_CNT_W = $clog2(VALUE_W);

  localparam int IN_TDATA_W = ((VALUE_W + PAD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_SPACE = 8'd32;

endpackage

`default_nettype wire

// File: rtl/int_to_padded_decimal_core.sv
`default_nettype none
// signed 32-bit integer to padded ascii decimal text, one character per transfer
// input channel (s_axis): one transfer carries a value and a signed field width;
//   tready is high only while the block is idle, so items are taken one at a time
// output channel (m_axis): one character per transfer, tlast on the final one
//   of each value's text; characters are spaces, a minus sign or digits
// width 0 gives no padding, positive pads leading spaces in front of the sign,
//   negative pads trailing spaces; text is never cut, width saturates at
//   MAX_FIELD_WIDTH
// sequence: after the input transfer, binary to bcd conversion of all 32 bits
//   (shift and add-3, one bit per cycle through a shared digit-correct unit),
//   then stripping 0 to 9 leading zero digits and sizing the field, before
//   the first character is loaded into the output register
// throughput: characters then leave one per cycle while the receiver keeps
//   tready high; a new item is taken only once the last character of the
//   current one has been loaded into the output register
// the output register holds the last character until it is taken, while the
//   block already accepts and converts the next value
// receiver stall: tvalid and tdata hold, character emission pauses
// reset: rst_ni is asynchronous, active low; the block returns idle with no
//   output pending
module int_to_padded_decimal_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] value (signed), [38:32] pad_width (signed), [39] zero
  input  wire [idp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [7:0] text_char
  output logic [idp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // last_char
  output logic                             m_axis_tlast
);
  import idp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [VALUE_W-1:0]     mag_q;
  logic [BCD_W-1:0]       bcd_q;
  logic [BIT_CNT_W-1:0]   bit_q;
  logic [NDIG_W-1:0]      ndig_q;
  logic                   neg_q;
  logic [PAD_W-1:0]       pad_w_q;

  // emission counters: leading spaces, trailing spaces, characters left, sign
  logic [CNT_W-1:0]       lead_q;
  logic [CNT_W-1:0]       trail_q;
  logic [CNT_W-1:0]       remain_q;
  logic                   sign_q;

  logic                   m_valid_q;
  logic [7:0]             m_char_q;
  logic                   m_last_q;

  logic [BCD_W-1:0]       bcd_adj;
  logic                   in_xfer;
  logic [VALUE_W-1:0]     in_value;
  logic [PAD_W-1:0]       in_pad;

  // field sizing
  logic [PAD_W-1:0]       wmag;
  logic [CNT_W-1:0]       wsat;
  logic [CNT_W-1:0]       textlen;
  logic [CNT_W-1:0]       total;
  logic [CNT_W-1:0]       pad;
  logic                   pad_left;

  logic                   out_free;
  logic                   trim_step;
  logic                   emit_fire;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_value      = s_axis_tdata[VALUE_W-1:0];
  assign in_pad        = s_axis_tdata[VALUE_W +: PAD_W];

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_char_q;
  assign m_axis_tlast  = m_last_q;

  assign out_free  = !m_valid_q || m_axis_tready;
  assign trim_step = (bcd_q[BCD_W-1 -: 4] == 4'd0) && (ndig_q > NDIG_W'(1));
  // a new character is loaded into the output register
  assign emit_fire = (state_q == ST_EMIT) && (remain_q != '0) && out_free;

  // shared add-3 correction over all bcd digits before each shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // width magnitude, saturation and pad count
  always_comb begin
    pad_left = !pad_w_q[PAD_W-1];
    wmag     = pad_left ? pad_w_q : (PAD_W'(0) - pad_w_q);
    if (32'(wmag) > 32'(MAX_FIELD_WIDTH)) begin
      wsat = CNT_W'(MAX_FIELD_WIDTH);
    end else begin
      wsat = CNT_W'(wmag);
    end
    textlen = CNT_W'(ndig_q) + CNT_W'(neg_q);
    total   = (textlen < wsat) ? wsat : textlen;
    pad     = total - textlen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      m_char_q  <= '0;
      m_last_q  <= 1'b0;
      remain_q  <= '0;
      lead_q    <= '0;
      trail_q   <= '0;
      sign_q    <= 1'b0;
      bit_q     <= '0;
      ndig_q    <= '0;
      neg_q     <= 1'b0;
      mag_q     <= '0;
      bcd_q     <= '0;
      pad_w_q   <= '0;
    end else begin
      if (emit_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            neg_q   <= in_value[VALUE_W-1];
            mag_q   <= in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
            pad_w_q <= in_pad;
            bcd_q   <= '0;
            bit_q   <= '0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
          mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
          bit_q <= bit_q + BIT_CNT_W'(1);
          if (bit_q == BIT_CNT_W'(VALUE_W - 1)) begin
            ndig_q  <= NDIG_W'(NUM_DIGITS);
            state_q <= ST_TRIM;
          end
        end
        ST_TRIM: begin
          // drop leading zero digits, keep at least one
          if (trim_step) begin
            bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
            ndig_q <= ndig_q - NDIG_W'(1);
          end else begin
            lead_q   <= pad_left ? pad : '0;
            trail_q  <= pad_left ? '0 : pad;
            sign_q   <= neg_q;
            remain_q <= total;
            state_q  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (remain_q == '0) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            m_last_q  <= (remain_q == CNT_W'(1));
            remain_q  <= remain_q - CNT_W'(1);
            priority if (lead_q != '0) begin
              m_char_q <= CH_SPACE;
              lead_q   <= lead_q - CNT_W'(1);
            end else if (sign_q) begin
              m_char_q <= CH_MINUS;
              sign_q   <= 1'b0;
            end else if (ndig_q != '0) begin
              m_char_q <= CH_ZERO + {4'd0, bcd_q[BCD_W-1 -: 4]};
              bcd_q    <= {bcd_q[BCD_W-5:0], 4'd0};
              ndig_q   <= ndig_q - NDIG_W'(1);
            end else begin
              m_char_q <= CH_SPACE;
              trail_q  <= trail_q - CNT_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/idp_checker.sv
`default_nettype none

module idp_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              s_axis_tvalid,
  input wire                              s_axis_tready,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [idp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire                              m_axis_tlast
);
  import idp_pkg::*;

  // stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // only spaces, minus or digits
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == CH_SPACE) || (m_axis_tdata == CH_MINUS) ||
      ((m_axis_tdata >= CH_ZERO) && (m_axis_tdata <= CH_ZERO + 8'd9)))
    else $error("illegal character");

  // a minus sign is never the last character of a text
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata == CH_MINUS) |-> !m_axis_tlast)
    else $error("text ends in a minus sign");

  // busy during conversion after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken during conversion");

endmodule

bind int_to_padded_decimal_core idp_checker u_idp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
